// ===== rtl/k_smallest_sorted_list_assert.svh =====
// Assertion macros used by the k-smallest list top level
`ifndef K_SMALLEST_SORTED_LIST_ASSERT_SVH
`define K_SMALLEST_SORTED_LIST_ASSERT_SVH

// same-cycle implication
`define KSL_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("k_smallest_sorted_list: same-cycle check failed");

// next-cycle implication
`define KSL_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("k_smallest_sorted_list: next-cycle check failed");

`endif

// ===== rtl/ksl_pkg.sv =====
// Package: widths, constants and cell control type for the k-smallest list
package ksl_pkg;

   localparam int MAX_K_DEFAULT = 8;
   localparam int DIST_W        = 32;
   localparam int CNT_W         = 7;
   localparam int SLOT_W        = 6;

   typedef logic [DIST_W-1:0] dist_type;
   typedef logic [CNT_W-1:0]  count_type;
   typedef logic [SLOT_W-1:0] slot_type;

   localparam count_type K_RESET = 7'd8;

   typedef struct packed {
      logic      insert_en;
      logic      rotate_en;
      count_type count;
      count_type k_eff;
   } cell_ctl_type;

endpackage

// ===== rtl/ksl_if.sv =====
// Valid/ready channel interfaces for requests and responses
interface ksl_req_if
   import ksl_pkg::*;
   ();
   logic     valid;
   logic     ready;
   dist_type candidate_distance;
   logic     start_query;
   logic     last_candidate;

   modport source (output valid, output candidate_distance, output start_query,
                   output last_candidate, input ready);
   modport sink   (input valid, input candidate_distance, input start_query,
                   input last_candidate, output ready);
endinterface

interface ksl_rsp_if
   import ksl_pkg::*;
   ();
   logic     valid;
   logic     ready;
   slot_type slot_index;
   dist_type slot_distance;
   logic     final_slot;

   modport source (output valid, output slot_index, output slot_distance,
                   output final_slot, input ready);
   modport sink   (input valid, input slot_index, input slot_distance,
                   input final_slot, output ready);
endinterface

// ===== rtl/ksl_cell.sv =====
// One slot of the sorted list: compare, insert/shift, rotate to drain
module ksl_cell
   import ksl_pkg::*;
#(
   parameter int CELL_IDX = 0
) (
   input  logic         clock,
   input  cell_ctl_type ctl,
   input  dist_type     cand,
   input  logic         left_le,
   input  dist_type     left_val,
   input  dist_type     right_val,
   input  dist_type     head_val,
   output logic         le_out,
   output dist_type     value_out
);

   localparam count_type MY_IDX  = CNT_W'(CELL_IDX);
   localparam count_type MY_NEXT = CNT_W'(CELL_IDX + 1);

   dist_type value_ff;
   dist_type value_in;

   assign le_out    = (MY_IDX < ctl.count) && (value_ff <= cand);
   assign value_out = value_ff;

   always_comb begin
      value_in = value_ff;
      if (ctl.insert_en) begin
         if (!le_out && (MY_IDX < ctl.k_eff)) begin
            if (left_le) begin
               value_in = cand;
            end else if (MY_IDX <= ctl.count) begin
               value_in = left_val;
            end
         end
      end else if (ctl.rotate_en) begin
         if (MY_NEXT == ctl.count) begin
            value_in = head_val;
         end else if (MY_NEXT < ctl.count) begin
            value_in = right_val;
         end
      end
   end

   always_ff @(posedge clock) begin
      value_ff <= value_in;
   end

endmodule

// ===== rtl/k_smallest_sorted_list.sv =====
// Top level: k-smallest sorted insertion list built from a row of cells
//
//  channel | dir | handshake        | payload
//  req_ch  | in  | valid/ready      | candidate_distance, start_query, last_candidate
//  rsp_ch  | out | valid/ready      | slot_index, slot_distance, final_slot
//  csr     | in  | csr_wr_en        | csr_wr_data (k_in_use)
//
// On a request without last_candidate all cells compare and shift at once.
// A request with last_candidate then drains the n held entries, n the count after insertion:
// the row rotates one slot per cycle into the response register, then returns intact.
// Response stalls hold the rotation; req_ch.ready is low while draining.
// Reset is synchronous and clears the held count and k_in_use (to 8); slot values stay.
`include "k_smallest_sorted_list_assert.svh"

module k_smallest_sorted_list
   import ksl_pkg::*;
#(
   parameter int MAX_K = MAX_K_DEFAULT
) (
   input  logic         clock,
   input  logic         reset,
   ksl_req_if.sink      req_ch,
   ksl_rsp_if.source    rsp_ch,
   input  logic         csr_wr_en,
   input  count_type    csr_wr_data
);

   typedef enum logic {
      ST_IDLE,
      ST_EMIT
   } state_type;

   state_type    state_ff, state_in;
   count_type    held_count_ff, held_count_in;
   count_type    idx_ff, idx_in;
   count_type    k_in_use_ff;
   logic         rsp_valid_ff, rsp_valid_in;
   slot_type     rsp_slot_ff, rsp_slot_in;
   dist_type     rsp_dist_ff, rsp_dist_in;
   logic         rsp_final_ff, rsp_final_in;

   count_type    k_eff;
   count_type    n_ins;
   logic         req_accept;
   logic         emit_step;
   logic         emit_last;
   cell_ctl_type ctl;

   logic     [MAX_K:0]   le_chain;
   dist_type [MAX_K-1:0] cell_val;

   always_comb begin
      if (k_in_use_ff == '0) begin
         k_eff = CNT_W'(1);
      end else if (k_in_use_ff > CNT_W'(MAX_K)) begin
         k_eff = CNT_W'(MAX_K);
      end else begin
         k_eff = k_in_use_ff;
      end
   end

   assign req_ch.ready = (state_ff == ST_IDLE);
   assign req_accept   = req_ch.valid && req_ch.ready;
   assign emit_step    = (state_ff == ST_EMIT) && (!rsp_valid_ff || rsp_ch.ready);
   assign emit_last    = (idx_ff == held_count_ff - CNT_W'(1));

   always_comb begin
      if (req_ch.start_query) begin
         n_ins = '0;
      end else if (held_count_ff < k_eff) begin
         n_ins = held_count_ff;
      end else begin
         n_ins = k_eff;
      end
   end

   assign ctl.insert_en = req_accept;
   assign ctl.rotate_en = emit_step;
   assign ctl.count     = req_accept ? n_ins : held_count_ff;
   assign ctl.k_eff     = k_eff;

   assign le_chain[0] = 1'b1;

   for (genvar g = 0; g < MAX_K; g++) begin : g_cell
      ksl_cell #(
         .CELL_IDX (g)
      ) u_cell (
         .clock     (clock),
         .ctl       (ctl),
         .cand      (req_ch.candidate_distance),
         .left_le   (le_chain[g]),
         .left_val  ((g == 0) ? req_ch.candidate_distance : cell_val[(g == 0) ? 0 : g-1]),
         .right_val ((g == MAX_K-1) ? cell_val[0] : cell_val[(g == MAX_K-1) ? g : g+1]),
         .head_val  (cell_val[0]),
         .le_out    (le_chain[g+1]),
         .value_out (cell_val[g])
      );
   end

   always_comb begin
      state_in      = state_ff;
      held_count_in = held_count_ff;
      idx_in        = idx_ff;
      rsp_valid_in  = rsp_valid_ff;
      rsp_slot_in   = rsp_slot_ff;
      rsp_dist_in   = rsp_dist_ff;
      rsp_final_in  = rsp_final_ff;
      if (rsp_ch.ready) begin
         rsp_valid_in = 1'b0;
      end
      case (state_ff)
         ST_IDLE: begin
            if (req_accept) begin
               held_count_in = (n_ins < k_eff) ? n_ins + CNT_W'(1) : n_ins;
               if (req_ch.last_candidate) begin
                  state_in = ST_EMIT;
                  idx_in   = '0;
               end
            end
         end
         ST_EMIT: begin
            if (emit_step) begin
               rsp_valid_in = 1'b1;
               rsp_slot_in  = SLOT_W'(idx_ff);
               rsp_dist_in  = cell_val[0];
               rsp_final_in = emit_last;
               if (emit_last) begin
                  state_in = ST_IDLE;
               end else begin
                  idx_in = idx_ff + CNT_W'(1);
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         held_count_ff <= '0;
         idx_ff        <= '0;
         rsp_valid_ff  <= 1'b0;
         k_in_use_ff   <= K_RESET;
      end else begin
         state_ff      <= state_in;
         held_count_ff <= held_count_in;
         idx_ff        <= idx_in;
         rsp_valid_ff  <= rsp_valid_in;
         if (csr_wr_en) begin
            k_in_use_ff <= csr_wr_data;
         end
      end
      rsp_slot_ff  <= rsp_slot_in;
      rsp_dist_ff  <= rsp_dist_in;
      rsp_final_ff <= rsp_final_in;
   end

   assign rsp_ch.valid         = rsp_valid_ff;
   assign rsp_ch.slot_index    = rsp_slot_ff;
   assign rsp_ch.slot_distance = rsp_dist_ff;
   assign rsp_ch.final_slot    = rsp_final_ff;

   `KSL_ASSERT_NEXT(a_last_starts_drain, clock, reset,
      req_accept && req_ch.last_candidate, state_ff == ST_EMIT)
   `KSL_ASSERT_NOW(a_drain_nonempty, clock, reset,
      state_ff == ST_EMIT, held_count_ff != '0 && idx_ff < held_count_ff)
   `KSL_ASSERT_NEXT(a_final_ends_drain, clock, reset,
      emit_step && emit_last, state_ff == ST_IDLE && rsp_valid_ff && rsp_final_ff)
   `KSL_ASSERT_NOW(a_count_bounded, clock, reset,
      1'b1, held_count_ff <= CNT_W'(MAX_K))

endmodule

// ===== tb/ksl_board_pkg.sv =====
`timescale 1ns / 100ps
// Scoreboard class that predicts the ranked k-smallest list and checks each response
package ksl_board_pkg;
   import ksl_pkg::*;

   localparam int LIST_DEPTH = MAX_K_DEFAULT;

   typedef struct packed {
      slot_type rank;
      dist_type distance;
      logic     final_slot;
   } ranked_slot_type;

   class nearest_list_board;
      dist_type        held_list[LIST_DEPTH];
      int unsigned     held_count;
      count_type       k_reg;
      ranked_slot_type expected_slots[$];
      int unsigned     mismatches;

      function new();
         foreach (held_list[i]) held_list[i] = '0;
         held_count = 0;
         k_reg      = K_RESET;
         mismatches = 0;
      endfunction

      function void write_k(count_type value);
         k_reg = value;
      endfunction

      function int unsigned k_effective();
         if (k_reg == 0) return 1;
         if (k_reg > LIST_DEPTH) return LIST_DEPTH;
         return k_reg;
      endfunction

      function void take_candidate(dist_type cand, logic start, logic last);
         int unsigned     k;
         int unsigned     n;
         int unsigned     pos;
         int unsigned     i;
         ranked_slot_type slot;
         k = k_effective();
         if (start) held_count = 0;
         n = (held_count < k) ? held_count : k;
         pos = 0;
         while (pos < n && held_list[pos] <= cand) pos++;
         if (pos < k) begin
            i = (n < k) ? n : k - 1;
            while (i > pos) begin
               held_list[i] = held_list[i - 1];
               i--;
            end
            held_list[pos] = cand;
            if (n < k) n++;
         end
         held_count = n;
         if (last) begin
            for (i = 0; i < n; i++) begin
               slot.rank       = slot_type'(i);
               slot.distance   = held_list[i];
               slot.final_slot = (i + 1 == n);
               expected_slots.push_back(slot);
            end
         end
      endfunction

      function void check_slot(slot_type rank, dist_type distance, logic final_slot);
         ranked_slot_type exp_slot;
         if (expected_slots.size() == 0) begin
            $display("%0t: response with nothing expected: rank %0d distance %h final %b",
                     $time, rank, distance, final_slot);
            mismatches++;
            return;
         end
         exp_slot = expected_slots.pop_front();
         if (exp_slot.rank !== rank) begin
            $display("%0t: slot_index expected %0d actual %0d", $time, exp_slot.rank, rank);
            mismatches++;
         end
         if (exp_slot.distance !== distance) begin
            $display("%0t: slot_distance expected %h actual %h",
                     $time, exp_slot.distance, distance);
            mismatches++;
         end
         if (exp_slot.final_slot !== final_slot) begin
            $display("%0t: final_slot expected %b actual %b",
                     $time, exp_slot.final_slot, final_slot);
            mismatches++;
         end
      endfunction

      function int unsigned pending();
         return expected_slots.size();
      endfunction

      function bit clean_finish();
         if (expected_slots.size() != 0) begin
            $display("%0t: %0d expected responses never arrived", $time, expected_slots.size());
            mismatches++;
         end
         return mismatches == 0;
      endfunction
   endclass

endpackage

// ===== tb/k_smallest_sorted_list_tb.sv =====
`timescale 1ns / 100ps
// Testbench top: drives candidate queries and k settings, checks ranked responses
module k_smallest_sorted_list_tb;
   import ksl_pkg::*;
   import ksl_board_pkg::*;

   localparam int CYCLE_LIMIT     = 400000;
   localparam int DRAIN_CYCLES    = MAX_K_DEFAULT + 4;
   localparam int HOLD_OFF_CYCLES = 400;

   logic      clock       = 1'b0;
   logic      reset       = 1'b1;
   logic      csr_wr_en   = 1'b0;
   count_type csr_wr_data = '0;

   int unsigned send_idle_pct  = 0;
   int unsigned recv_stall_pct = 0;
   int unsigned hold_requests  = 0;
   int unsigned hold_served    = 0;
   int unsigned hold_left      = 0;
   int unsigned cycle_count    = 0;

   int unsigned idle_plan[4]  = '{0, 85, 0, 32};
   int unsigned stall_plan[4] = '{0, 0, 85, 32};
   count_type   k_plan[4]     = '{7'd8, 7'd4, 7'd64, 7'd1};

   nearest_list_board board;

   ksl_req_if req_ch ();
   ksl_rsp_if rsp_ch ();

   k_smallest_sorted_list dut (
      .clock       (clock),
      .reset       (reset),
      .req_ch      (req_ch),
      .rsp_ch      (rsp_ch),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   always #5 clock = ~clock;

   always @(posedge clock) begin
      if (hold_left != 0) begin
         rsp_ch.ready <= 1'b0;
         hold_left <= hold_left - 1;
      end else if (hold_served != hold_requests) begin
         rsp_ch.ready <= 1'b0;
         hold_left <= HOLD_OFF_CYCLES;
         hold_served <= hold_served + 1;
      end else begin
         rsp_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
      end
   end

   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_ch.valid && rsp_ch.ready)
            board.check_slot(rsp_ch.slot_index, rsp_ch.slot_distance, rsp_ch.final_slot);
         if (req_ch.valid && req_ch.ready)
            board.take_candidate(req_ch.candidate_distance, req_ch.start_query,
                                 req_ch.last_candidate);
      end
   end

   initial begin
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("k_smallest_sorted_list: mismatch");
      $finish;
   end

   function automatic dist_type pick_distance();
      case ($urandom_range(9))
         0:       return '0;
         1:       return '1;
         2, 3:    return dist_type'($urandom_range(15));
         4:       return {16'($urandom_range(3)), 16'h0000};
         default: return $urandom();
      endcase
   endfunction

   task automatic send_request(dist_type distance, logic start, logic last);
      while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
         req_ch.valid <= 1'b0;
         @(posedge clock);
      end
      req_ch.valid              <= 1'b1;
      req_ch.candidate_distance <= distance;
      req_ch.start_query        <= start;
      req_ch.last_candidate     <= last;
      do @(posedge clock); while (!req_ch.ready);
   endtask

   task automatic send_query(int len, logic opens);
      for (int i = 0; i < len; i++)
         send_request(pick_distance(), opens && (i == 0), i == len - 1);
   endtask

   task automatic run_random(int unsigned items);
      int unsigned sent;
      int          len;
      sent = 0;
      while (sent < items) begin
         if ($urandom_range(9) == 0) begin
            send_request(pick_distance(), 1'($urandom_range(1)), 1'($urandom_range(1)));
            sent++;
         end else begin
            len = $urandom_range(1, 12);
            send_query(len, $urandom_range(9) != 0);
            sent += len;
         end
      end
      req_ch.valid <= 1'b0;
   endtask

   task automatic settle();
      @(posedge clock);
      while (board.pending() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_k(count_type value);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      board.write_k(value);
   endtask

   initial begin
      board = new();
      req_ch.valid              <= 1'b0;
      req_ch.candidate_distance <= '0;
      req_ch.start_query        <= 1'b0;
      req_ch.last_candidate     <= 1'b0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // ties, extremes, carry-over without start
      send_request(32'hFFFF_FFFF, 1'b1, 1'b0);
      send_request(32'h0000_0000, 1'b0, 1'b0);
      send_request(32'h8000_0000, 1'b0, 1'b0);
      send_request(32'h0001_0000, 1'b0, 1'b0);
      send_request(32'h0000_0005, 1'b0, 1'b0);
      send_request(32'h0000_0005, 1'b0, 1'b1);
      send_request(32'h0000_0003, 1'b0, 1'b1);
      send_request(32'hFFFF_FFFF, 1'b0, 1'b1);
      send_request(32'h1234_5678, 1'b1, 1'b1);
      req_ch.valid <= 1'b0;
      settle();

      write_k(7'd1);
      send_request(32'd9, 1'b1, 1'b0);
      send_request(32'd4, 1'b0, 1'b0);
      send_request(32'd7, 1'b0, 1'b1);
      req_ch.valid <= 1'b0;
      settle();

      write_k(7'd0);
      send_request(32'd2, 1'b1, 1'b1);
      req_ch.valid <= 1'b0;
      settle();

      // overfill past the depth, then shrink k with entries held
      write_k(7'd127);
      for (int i = 0; i < 9; i++)
         send_request(32'd100 - 32'(i * 3), i == 0, i == 8);
      req_ch.valid <= 1'b0;
      settle();
      write_k(7'd3);
      send_request(32'd50, 1'b0, 1'b1);
      req_ch.valid <= 1'b0;
      settle();
      write_k(7'd8);
      send_request(32'd1, 1'b0, 1'b1);
      req_ch.valid <= 1'b0;
      settle();

      for (int p = 0; p < 4; p++) begin
         send_idle_pct  = idle_plan[p];
         recv_stall_pct = stall_plan[p];
         write_k(k_plan[p]);
         run_random(42);
         settle();
      end

      // hold the response side while requests keep coming
      send_idle_pct  = 0;
      recv_stall_pct = 0;
      write_k(7'd8);
      hold_requests++;
      run_random(26);
      settle();

      if (board.clean_finish()) begin
         $display("k_smallest_sorted_list: match");
      end else begin
         $display("k_smallest_sorted_list: mismatch");
      end
      $finish;
   end

endmodule
